FILE: hdl/lavm_pkg.sv
// Shared constants and types for the look-at view matrix block.
// Used by lavm_prescale, lavm_norm and look_at_view_matrix_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lavm_pkg;

    // Default fixed-point format of the coordinates.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed widths of the result fields.
    localparam int AXIS_W   = 18;
    localparam int OFFSET_W = 32;
    localparam int ROW_W    = 2;

    // The largest prescaled magnitude has its leading one at bit PS_W-1.
    localparam int PS_W = 30;

    // Rows per request.
    localparam int ROWS = 3;

    localparam logic [ROW_W-1:0] ROW_X = 2'd0;
    localparam logic [ROW_W-1:0] ROW_Y = 2'd1;
    localparam logic [ROW_W-1:0] ROW_Z = 2'd2;

    localparam logic signed [OFFSET_W-1:0] OFF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OFFSET_W-1:0] OFF_MIN = 32'sh8000_0000;

    // Row sequencer states.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ROW0 = 4'b0010,
        PH_ROW1 = 4'b0100,
        PH_ROW2 = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

FILE: hdl/lavm_prescale.sv
// Three-stage vector prescaler: magnitudes are shifted so the largest one
// has its leading one at bit PS_W-1. Depends on lavm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lavm_prescale #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic [2:0][IN_W-1:0]                i_vec,
    input  wire logic [SIDE_W-1:0]                   i_side,
    output logic                                     o_valid,
    output logic [2:0][lavm_pkg::PS_W-1:0]           o_mag,
    output logic [2:0]                               o_neg,
    output logic [SIDE_W-1:0]                        o_side
);

    localparam int PS_W  = lavm_pkg::PS_W;
    localparam int LEN_W = $clog2(IN_W + 1);
    localparam int SH_W  = IN_W + PS_W;

    // Stage A: magnitudes and their maximum.
    logic [2:0][IN_W-1:0] n_a_mag;
    logic [2:0]           n_a_neg;
    logic [IN_W-1:0]      n_a_max;
    logic [2:0][IN_W-1:0] r_a_mag;
    logic [2:0]           r_a_neg;
    logic [IN_W-1:0]      r_a_max;
    logic [SIDE_W-1:0]    r_a_side;
    logic                 r_a_valid;

    // Stage B: bit length of the maximum.
    logic [LEN_W-1:0]     n_b_len;
    logic [2:0][IN_W-1:0] r_b_mag;
    logic [2:0]           r_b_neg;
    logic [LEN_W-1:0]     r_b_len;
    logic [SIDE_W-1:0]    r_b_side;
    logic                 r_b_valid;

    // Stage C: the shift.
    logic [2:0][PS_W-1:0] n_c_mag;
    logic [2:0][PS_W-1:0] r_c_mag;
    logic [2:0]           r_c_neg;
    logic [SIDE_W-1:0]    r_c_side;
    logic                 r_c_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_neg[i] = i_vec[i][IN_W-1];
            n_a_mag[i] = n_a_neg[i] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        n_a_max = (n_a_mag[0] > n_a_mag[1]) ? n_a_mag[0] : n_a_mag[1];
        if (n_a_mag[2] > n_a_max) begin
            n_a_max = n_a_mag[2];
        end
    end

    always_comb begin
        n_b_len = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (r_a_max[i]) begin
                n_b_len = LEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        logic [SH_W-1:0] sh;
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (int'(r_b_len) > PS_W) begin
                sh = SH_W'(r_b_mag[i]) >> (int'(r_b_len) - PS_W);
            end else begin
                sh = SH_W'(r_b_mag[i]) << (PS_W - int'(r_b_len));
            end
            n_c_mag[i] = sh[PS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= n_a_mag;
        r_a_neg  <= n_a_neg;
        r_a_max  <= n_a_max;
        r_a_side <= i_side;
        r_b_mag  <= r_a_mag;
        r_b_neg  <= r_a_neg;
        r_b_len  <= n_b_len;
        r_b_side <= r_a_side;
        r_c_mag  <= n_c_mag;
        r_c_neg  <= r_b_neg;
        r_c_side <= r_b_side;
    end

    assign o_valid = r_c_valid;
    assign o_mag   = r_c_mag;
    assign o_neg   = r_c_neg;
    assign o_side  = r_c_side;

endmodule

`default_nettype wire

FILE: hdl/lavm_norm.sv
// Pipelined vector normalizer: prescale, sum of squares, one square-root bit
// per stage, one quotient bit per stage. Depends on lavm_pkg, lavm_prescale.
`timescale 1ns / 1ps
`default_nettype none

module lavm_norm #(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [2:0][IN_W-1:0]          i_vec,
    input  wire logic [SIDE_W-1:0]             i_side,
    output logic                               o_valid,
    output logic [2:0][FRAC_BITS+1:0]          o_axis,
    output logic                               o_deg,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int PS_W     = lavm_pkg::PS_W;
    localparam int SUM_W    = 2 * PS_W + 2;
    localparam int SQ_STEPS = PS_W + 1;
    localparam int N_W      = PS_W + 1;
    localparam int NUM_W    = PS_W + FRAC_BITS + 1;
    localparam int Q_W      = FRAC_BITS + 1;
    localparam int AX_W     = FRAC_BITS + 2;

    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][PS_W-1:0] mag;
        logic [SIDE_W-1:0]    side;
    } t_sq_car;

    typedef struct packed {
        logic [2:0]        neg;
        logic [SIDE_W-1:0] side;
    } t_div_car;

    logic                 p_valid;
    logic [2:0][PS_W-1:0] p_mag;
    logic [2:0]           p_neg;
    logic [SIDE_W-1:0]    p_side;

    lavm_prescale #(
        .IN_W   (IN_W),
        .SIDE_W (SIDE_W)
    ) u_prescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_vec   (i_vec),
        .i_side  (i_side),
        .o_valid (p_valid),
        .o_mag   (p_mag),
        .o_neg   (p_neg),
        .o_side  (p_side)
    );

    // Squares.
    logic [2:0][2*PS_W-1:0] n_s1_sq;
    logic [2:0][2*PS_W-1:0] r_s1_sq;
    t_sq_car                r_s1_car;
    logic                   r_s1_valid;

    // Square root, one result bit per stage; index 0 holds the sum.
    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  r_sx  [0:SQ_STEPS];
    logic [SUM_W-1:0]  r_sr  [0:SQ_STEPS];
    t_sq_car           r_sc  [0:SQ_STEPS];
    logic [SQ_STEPS:0] r_sv;
    logic [SUM_W-1:0]  n_sx  [0:SQ_STEPS-1];
    logic [SUM_W-1:0]  n_sr  [0:SQ_STEPS-1];

    // Division, one quotient bit per stage; index 0 holds the numerators.
    logic [N_W-1:0]             sq_n;
    logic [2:0][NUM_W-1:0]      n_num;
    logic [2:0][NUM_W-1:0]      r_dr [0:Q_W];
    logic [2:0][Q_W-1:0]        r_dq [0:Q_W];
    logic [N_W-1:0]             r_dn [0:Q_W];
    t_div_car                   r_dc [0:Q_W];
    logic [Q_W:0]               r_dv;
    logic [2:0][NUM_W-1:0]      n_dr [0:Q_W-1];
    logic [2:0][Q_W-1:0]        n_dq [0:Q_W-1];

    // Output stage.
    logic                  n_o_deg;
    logic [2:0][AX_W-1:0]  n_o_axis;
    logic [2:0][AX_W-1:0]  r_o_axis;
    logic                  r_o_deg;
    logic [SIDE_W-1:0]     r_o_side;
    logic                  r_o_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_sq[i] = p_mag[i] * p_mag[i];
        end
        n_sum = SUM_W'(r_s1_sq[0]) + SUM_W'(r_s1_sq[1]) + SUM_W'(r_s1_sq[2]);
    end

    always_comb begin
        logic [SUM_W-1:0] bitv;
        logic [SUM_W-1:0] trial;
        bitv  = '0;
        trial = '0;
        for (int k = 0; k < SQ_STEPS; k++) begin
            bitv  = SUM_W'(1) << (2 * (SQ_STEPS - 1 - k));
            trial = r_sr[k] + bitv;
            if (r_sx[k] >= trial) begin
                n_sx[k] = r_sx[k] - trial;
                n_sr[k] = (r_sr[k] >> 1) + bitv;
            end else begin
                n_sx[k] = r_sx[k];
                n_sr[k] = r_sr[k] >> 1;
            end
        end
    end

    assign sq_n = r_sr[SQ_STEPS][N_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (NUM_W'(r_sc[SQ_STEPS].mag[i]) << FRAC_BITS) + NUM_W'(sq_n >> 1);
        end
    end

    always_comb begin
        logic [NUM_W-1:0] dvs;
        dvs = '0;
        for (int j = 0; j < Q_W; j++) begin
            dvs = NUM_W'(r_dn[j]) << (Q_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (r_dr[j][i] >= dvs) begin
                    n_dr[j][i] = r_dr[j][i] - dvs;
                    n_dq[j][i] = r_dq[j][i] | (Q_W'(1) << (Q_W - 1 - j));
                end else begin
                    n_dr[j][i] = r_dr[j][i];
                    n_dq[j][i] = r_dq[j][i];
                end
            end
        end
    end

    // A zero sum of squares leaves the divisor at zero; the axis is forced to zero.
    always_comb begin
        n_o_deg = (r_dn[Q_W] == '0);
        for (int i = 0; i < 3; i++) begin
            if (n_o_deg) begin
                n_o_axis[i] = '0;
            end else if (r_dc[Q_W].neg[i]) begin
                n_o_axis[i] = ~AX_W'(r_dq[Q_W][i]) + 1'b1;
            end else begin
                n_o_axis[i] = AX_W'(r_dq[Q_W][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_sv       <= '0;
            r_dv       <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= p_valid;
            r_sv       <= {r_sv[SQ_STEPS-1:0], r_s1_valid};
            r_dv       <= {r_dv[Q_W-1:0], r_sv[SQ_STEPS]};
            r_o_valid  <= r_dv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sq       <= n_s1_sq;
        r_s1_car.neg  <= p_neg;
        r_s1_car.mag  <= p_mag;
        r_s1_car.side <= p_side;

        r_sx[0] <= n_sum;
        r_sr[0] <= '0;
        r_sc[0] <= r_s1_car;
        for (int k = 0; k < SQ_STEPS; k++) begin
            r_sx[k+1] <= n_sx[k];
            r_sr[k+1] <= n_sr[k];
            r_sc[k+1] <= r_sc[k];
        end

        r_dr[0]      <= n_num;
        r_dq[0]      <= '0;
        r_dn[0]      <= sq_n;
        r_dc[0].neg  <= r_sc[SQ_STEPS].neg;
        r_dc[0].side <= r_sc[SQ_STEPS].side;
        for (int j = 0; j < Q_W; j++) begin
            r_dr[j+1] <= n_dr[j];
            r_dq[j+1] <= n_dq[j];
            r_dn[j+1] <= r_dn[j];
            r_dc[j+1] <= r_dc[j];
        end

        r_o_axis <= n_o_axis;
        r_o_deg  <= n_o_deg;
        r_o_side <= r_dc[Q_W].side;
    end

    assign o_valid = r_o_valid;
    assign o_axis  = r_o_axis;
    assign o_deg   = r_o_deg;
    assign o_side  = r_o_side;

endmodule

`default_nettype wire

FILE: hdl/look_at_view_matrix_top.sv
// Right-handed look-at view matrix: three pipelined normalizers, two cross products, the
// offset dot products and a row sequencer. Depends on lavm_pkg, lavm_prescale and lavm_norm.
// Row 0 is sent in sequencer state PH_ROW0, rows 1 and 2 follow in PH_ROW1 and PH_ROW2.
// New requests enter while older ones are still in the pipeline; busy, set by each accepted
// request, holds off the next one for the single result port, and the receiver cannot stall.
// Reset is synchronous, active low, and clears valids, the busy count and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_top #(
    parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [COORD_WIDTH-1:0]          i_camera_x,
    input  wire logic [COORD_WIDTH-1:0]          i_camera_y,
    input  wire logic [COORD_WIDTH-1:0]          i_camera_z,
    input  wire logic [COORD_WIDTH-1:0]          i_target_x,
    input  wire logic [COORD_WIDTH-1:0]          i_target_y,
    input  wire logic [COORD_WIDTH-1:0]          i_target_z,
    input  wire logic [COORD_WIDTH-1:0]          i_up_x,
    input  wire logic [COORD_WIDTH-1:0]          i_up_y,
    input  wire logic [COORD_WIDTH-1:0]          i_up_z,
    output logic                                 o_valid,
    output logic [lavm_pkg::AXIS_W-1:0]          o_axis_x,
    output logic [lavm_pkg::AXIS_W-1:0]          o_axis_y,
    output logic [lavm_pkg::AXIS_W-1:0]          o_axis_z,
    output logic [lavm_pkg::OFFSET_W-1:0]        o_offset,
    output logic [lavm_pkg::ROW_W-1:0]           o_row_index,
    output logic                                 o_last_row,
    output logic                                 o_degenerate
);

    localparam int W     = COORD_WIDTH;
    localparam int AX_W  = FRAC_BITS + 2;
    localparam int D_W   = W + 1;
    localparam int UPS_W = lavm_pkg::PS_W + 1;
    localparam int PX_W  = UPS_W + AX_W;
    localparam int CX_W  = PX_W + 1;
    localparam int PY_W  = 2 * AX_W;
    localparam int CY_W  = PY_W + 1;
    localparam int PD_W  = AX_W + W;
    localparam int DS_W  = PD_W + 2;
    localparam int OF_W  = DS_W + 1;
    localparam int OW    = lavm_pkg::OFFSET_W;

    localparam logic [DS_W-1:0] RND = DS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [OF_W-1:0] SAT_HI = OF_W'(lavm_pkg::OFF_MAX);
    localparam logic signed [OF_W-1:0] SAT_LO = OF_W'(lavm_pkg::OFF_MIN);

    // Side data carried alongside the normalizers.
    typedef struct packed {
        logic [2:0][W-1:0] up;
        logic [2:0][W-1:0] cam;
    } t_uc;

    typedef struct packed {
        logic                 deg;
        logic [2:0][AX_W-1:0] z;
        logic [2:0][W-1:0]    cam;
    } t_zc;

    typedef struct packed {
        logic                 deg;
        logic [2:0][AX_W-1:0] z;
        logic [2:0][AX_W-1:0] x;
        logic [2:0][W-1:0]    cam;
    } t_zxc;

    // ------------------------------------------------------------------
    // Request acceptance. Busy holds off the next request after each accepted
    // one so that the row sequencer finishes one set of three rows before the next.
    // ------------------------------------------------------------------
    logic       accept;
    logic [1:0] n_busy_cnt;
    logic [1:0] r_busy_cnt;

    assign accept = start && !busy;
    assign busy   = (r_busy_cnt != 2'd0);

    always_comb begin
        if (accept) begin
            n_busy_cnt = 2'(lavm_pkg::ROWS - 1);
        end else if (r_busy_cnt != 2'd0) begin
            n_busy_cnt = r_busy_cnt - 2'd1;
        end else begin
            n_busy_cnt = r_busy_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage T0: difference vector from target to camera.
    // ------------------------------------------------------------------
    logic [2:0][D_W-1:0] n_t0_d;
    logic [2:0][D_W-1:0] r_t0_d;
    t_uc                 r_t0_side;
    logic                r_t0_valid;

    assign n_t0_d[0] = D_W'($signed(i_camera_x)) - D_W'($signed(i_target_x));
    assign n_t0_d[1] = D_W'($signed(i_camera_y)) - D_W'($signed(i_target_y));
    assign n_t0_d[2] = D_W'($signed(i_camera_z)) - D_W'($signed(i_target_z));

    // ------------------------------------------------------------------
    // z axis.
    // ------------------------------------------------------------------
    logic                 z_valid;
    logic [2:0][AX_W-1:0] z_axis;
    logic                 z_deg;
    t_uc                  z_side;
    t_zc                  z_car;

    lavm_norm #(
        .IN_W      (D_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_uc))
    ) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t0_valid),
        .i_vec   (r_t0_d),
        .i_side  (r_t0_side),
        .o_valid (z_valid),
        .o_axis  (z_axis),
        .o_deg   (z_deg),
        .o_side  (z_side)
    );

    assign z_car.deg = z_deg;
    assign z_car.z   = z_axis;
    assign z_car.cam = z_side.cam;

    // The up vector gets the same magnitude shift as a normalized vector.
    logic                         u_valid;
    logic [2:0][lavm_pkg::PS_W-1:0] u_mag;
    logic [2:0]                   u_neg;
    t_zc                          u_side;

    lavm_prescale #(
        .IN_W   (W),
        .SIDE_W ($bits(t_zc))
    ) u_prescale_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (z_valid),
        .i_vec   (z_side.up),
        .i_side  (z_car),
        .o_valid (u_valid),
        .o_mag   (u_mag),
        .o_neg   (u_neg),
        .o_side  (u_side)
    );

    // ------------------------------------------------------------------
    // Cross product up x z: products in C1, differences in C2.
    // ------------------------------------------------------------------
    logic signed [UPS_W-1:0] c_ups [3];
    logic signed [AX_W-1:0]  c_zs  [3];
    logic signed [PX_W-1:0]  n_c1p [6];
    logic signed [PX_W-1:0]  r_c1p [6];
    t_zc                     r_c1_car;
    logic                    r_c1_valid;
    logic [2:0][CX_W-1:0]    n_c2_t;
    logic [2:0][CX_W-1:0]    r_c2_t;
    t_zc                     r_c2_car;
    logic                    r_c2_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_ups[i] = u_neg[i] ? -$signed({1'b0, u_mag[i]}) : $signed({1'b0, u_mag[i]});
            c_zs[i]  = $signed(u_side.z[i]);
        end
        n_c1p[0] = c_ups[1] * c_zs[2];
        n_c1p[1] = c_ups[2] * c_zs[1];
        n_c1p[2] = c_ups[2] * c_zs[0];
        n_c1p[3] = c_ups[0] * c_zs[2];
        n_c1p[4] = c_ups[0] * c_zs[1];
        n_c1p[5] = c_ups[1] * c_zs[0];
        for (int i = 0; i < 3; i++) begin
            n_c2_t[i] = CX_W'(r_c1p[2*i]) - CX_W'(r_c1p[2*i+1]);
        end
    end

    // ------------------------------------------------------------------
    // x axis.
    // ------------------------------------------------------------------
    logic                 x_valid;
    logic [2:0][AX_W-1:0] x_axis;
    logic                 x_deg;
    t_zc                  x_side;

    lavm_norm #(
        .IN_W      (CX_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_zc))
    ) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c2_valid),
        .i_vec   (r_c2_t),
        .i_side  (r_c2_car),
        .o_valid (x_valid),
        .o_axis  (x_axis),
        .o_deg   (x_deg),
        .o_side  (x_side)
    );

    // ------------------------------------------------------------------
    // Cross product z x x: products in Y1, differences in Y2.
    // ------------------------------------------------------------------
    logic signed [AX_W-1:0] y_zs  [3];
    logic signed [AX_W-1:0] y_xs  [3];
    logic signed [PY_W-1:0] n_y1p [6];
    logic signed [PY_W-1:0] r_y1p [6];
    t_zxc                   n_y1_car;
    t_zxc                   r_y1_car;
    logic                   r_y1_valid;
    logic [2:0][CY_W-1:0]   n_y2_t;
    logic [2:0][CY_W-1:0]   r_y2_t;
    t_zxc                   r_y2_car;
    logic                   r_y2_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            y_zs[i] = $signed(x_side.z[i]);
            y_xs[i] = $signed(x_axis[i]);
        end
        n_y1p[0] = y_zs[1] * y_xs[2];
        n_y1p[1] = y_zs[2] * y_xs[1];
        n_y1p[2] = y_zs[2] * y_xs[0];
        n_y1p[3] = y_zs[0] * y_xs[2];
        n_y1p[4] = y_zs[0] * y_xs[1];
        n_y1p[5] = y_zs[1] * y_xs[0];
        n_y1_car.deg = x_side.deg | x_deg;
        n_y1_car.z   = x_side.z;
        n_y1_car.x   = x_axis;
        n_y1_car.cam = x_side.cam;
        for (int i = 0; i < 3; i++) begin
            n_y2_t[i] = CY_W'(r_y1p[2*i]) - CY_W'(r_y1p[2*i+1]);
        end
    end

    // ------------------------------------------------------------------
    // y axis.
    // ------------------------------------------------------------------
    logic                 y_valid;
    logic [2:0][AX_W-1:0] y_axis;
    logic                 y_deg;
    t_zxc                 y_side;

    lavm_norm #(
        .IN_W      (CY_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(t_zxc))
    ) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_y2_valid),
        .i_vec   (r_y2_t),
        .i_side  (r_y2_car),
        .o_valid (y_valid),
        .o_axis  (y_axis),
        .o_deg   (y_deg),
        .o_side  (y_side)
    );

    // ------------------------------------------------------------------
    // Offsets: products in D1, rounded sums in D2, negation and saturation
    // in D3. Rounding adds half an LSB and floors, so halves go upward.
    // ------------------------------------------------------------------
    logic [2:0][2:0][AX_W-1:0] d_axes;
    logic signed [PD_W-1:0]    n_d1p [9];
    logic signed [PD_W-1:0]    r_d1p [9];
    logic [2:0][2:0][AX_W-1:0] r_d1_axes;
    logic                      r_d1_deg;
    logic                      r_d1_valid;
    logic signed [DS_W-1:0]    n_d2s [3];
    logic signed [DS_W-1:0]    r_d2s [3];
    logic [2:0][2:0][AX_W-1:0] r_d2_axes;
    logic                      r_d2_deg;
    logic                      r_d2_valid;
    logic signed [DS_W-1:0]    d3_q  [3];
    logic signed [OF_W-1:0]    d3_neg [3];
    logic [2:0][OW-1:0]        n_d3_off;
    logic [2:0][OW-1:0]        r_d3_off;
    logic [2:0][2:0][AX_W-1:0] r_d3_axes;
    logic                      r_d3_deg;
    logic                      r_d3_valid;

    assign d_axes[0] = y_side.x;
    assign d_axes[1] = y_axis;
    assign d_axes[2] = y_side.z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                n_d1p[3*k+i] = $signed(d_axes[k][i]) * $signed(y_side.cam[i]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_d2s[k] = DS_W'(r_d1p[3*k]) + DS_W'(r_d1p[3*k+1]) + DS_W'(r_d1p[3*k+2]) + RND;
        end
        for (int k = 0; k < 3; k++) begin
            d3_q[k]   = r_d2s[k] >>> FRAC_BITS;
            d3_neg[k] = -OF_W'(d3_q[k]);
            if (d3_neg[k] > SAT_HI) begin
                n_d3_off[k] = lavm_pkg::OFF_MAX;
            end else if (d3_neg[k] < SAT_LO) begin
                n_d3_off[k] = lavm_pkg::OFF_MIN;
            end else begin
                n_d3_off[k] = d3_neg[k][OW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Row sequencer: a finished matrix is latched and sent as rows x, y, z
    // in states PH_ROW0, PH_ROW1 and PH_ROW2. Busy spaces the requests so
    // that a new matrix never overtakes rows still being sent.
    // ------------------------------------------------------------------
    lavm_pkg::t_phase          n_phase;
    lavm_pkg::t_phase          r_phase;
    logic [2:0][2:0][AX_W-1:0] r_row_axes;
    logic [2:0][OW-1:0]        r_row_off;
    logic                      r_row_deg;
    logic [1:0]                sel;

    always_comb begin
        if (r_d3_valid) begin
            n_phase = lavm_pkg::PH_ROW0;
        end else begin
            unique case (r_phase)
                lavm_pkg::PH_ROW0: n_phase = lavm_pkg::PH_ROW1;
                lavm_pkg::PH_ROW1: n_phase = lavm_pkg::PH_ROW2;
                default:           n_phase = lavm_pkg::PH_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_phase)
            lavm_pkg::PH_ROW1: sel = lavm_pkg::ROW_Y;
            lavm_pkg::PH_ROW2: sel = lavm_pkg::ROW_Z;
            default:           sel = lavm_pkg::ROW_X;
        endcase
    end

    assign o_valid      = (r_phase != lavm_pkg::PH_IDLE);
    assign o_axis_x     = lavm_pkg::AXIS_W'($signed(r_row_axes[sel][0]));
    assign o_axis_y     = lavm_pkg::AXIS_W'($signed(r_row_axes[sel][1]));
    assign o_axis_z     = lavm_pkg::AXIS_W'($signed(r_row_axes[sel][2]));
    assign o_offset     = r_row_off[sel];
    assign o_row_index  = sel;
    assign o_last_row   = (r_phase == lavm_pkg::PH_ROW2);
    assign o_degenerate = r_row_deg;

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt <= 2'd0;
            r_t0_valid <= 1'b0;
            r_c1_valid <= 1'b0;
            r_c2_valid <= 1'b0;
            r_y1_valid <= 1'b0;
            r_y2_valid <= 1'b0;
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
            r_d3_valid <= 1'b0;
            r_phase    <= lavm_pkg::PH_IDLE;
        end else begin
            r_busy_cnt <= n_busy_cnt;
            r_t0_valid <= accept;
            r_c1_valid <= u_valid;
            r_c2_valid <= r_c1_valid;
            r_y1_valid <= x_valid;
            r_y2_valid <= r_y1_valid;
            r_d1_valid <= y_valid;
            r_d2_valid <= r_d1_valid;
            r_d3_valid <= r_d2_valid;
            r_phase    <= n_phase;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_t0_d           <= n_t0_d;
        r_t0_side.up[0]  <= i_up_x;
        r_t0_side.up[1]  <= i_up_y;
        r_t0_side.up[2]  <= i_up_z;
        r_t0_side.cam[0] <= i_camera_x;
        r_t0_side.cam[1] <= i_camera_y;
        r_t0_side.cam[2] <= i_camera_z;

        r_c1p    <= n_c1p;
        r_c1_car <= u_side;
        r_c2_t   <= n_c2_t;
        r_c2_car <= r_c1_car;

        r_y1p    <= n_y1p;
        r_y1_car <= n_y1_car;
        r_y2_t   <= n_y2_t;
        r_y2_car <= r_y1_car;

        r_d1p     <= n_d1p;
        r_d1_axes <= d_axes;
        r_d1_deg  <= y_side.deg | y_deg;
        r_d2s     <= n_d2s;
        r_d2_axes <= r_d1_axes;
        r_d2_deg  <= r_d1_deg;
        r_d3_off  <= n_d3_off;
        r_d3_axes <= r_d2_axes;
        r_d3_deg  <= r_d2_deg;

        if (r_d3_valid) begin
            r_row_axes <= r_d3_axes;
            r_row_off  <= r_d3_off;
            r_row_deg  <= r_d3_deg;
        end
    end

endmodule

`default_nettype wire

FILE: dv/look_at_view_matrix_top_tb.sv
// Self-checking testbench for look_at_view_matrix_top: a queued request driver,
// a row monitor and a fixed-point view matrix predictor.
// Depends on lavm_pkg and look_at_view_matrix_top.
`timescale 1ns / 1ps

module look_at_view_matrix_top_tb;

    localparam int CW = 32;
    localparam int FB = 16;
    // Depth from acceptance to the first row, used for the final drain.
    localparam int LATENCY = 3 * FB + 129;

    typedef struct packed {
        logic [CW-1:0] cam_x, cam_y, cam_z;
        logic [CW-1:0] tgt_x, tgt_y, tgt_z;
        logic [CW-1:0] up_x, up_y, up_z;
    } t_view_req;

    typedef struct packed {
        logic [lavm_pkg::AXIS_W-1:0]   ax, ay, az;
        logic [lavm_pkg::OFFSET_W-1:0] offset;
        logic [lavm_pkg::ROW_W-1:0]    row;
        logic                          last;
        logic                          degen;
    } t_matrix_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [CW-1:0] i_camera_x, i_camera_y, i_camera_z;
    logic [CW-1:0] i_target_x, i_target_y, i_target_z;
    logic [CW-1:0] i_up_x, i_up_y, i_up_z;
    logic o_valid;
    logic [lavm_pkg::AXIS_W-1:0] o_axis_x, o_axis_y, o_axis_z;
    logic [lavm_pkg::OFFSET_W-1:0] o_offset;
    logic [lavm_pkg::ROW_W-1:0] o_row_index;
    logic o_last_row;
    logic o_degenerate;

    look_at_view_matrix_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_camera_x(i_camera_x), .i_camera_y(i_camera_y), .i_camera_z(i_camera_z),
        .i_target_x(i_target_x), .i_target_y(i_target_y), .i_target_z(i_target_z),
        .i_up_x(i_up_x), .i_up_y(i_up_y), .i_up_z(i_up_z),
        .o_valid(o_valid), .o_axis_x(o_axis_x), .o_axis_y(o_axis_y),
        .o_axis_z(o_axis_z), .o_offset(o_offset), .o_row_index(o_row_index),
        .o_last_row(o_last_row), .o_degenerate(o_degenerate)
    );

    t_view_req   pending_reqs[$];
    t_matrix_row expected_rows[$];
    int          fail_count = 0;
    bit          stim_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. Vectors are held as signed 64-bit triples; all products
    // stay within 64 bits because prescaled magnitudes are under 2^30.
    // ------------------------------------------------------------------
    typedef logic signed [63:0] t_vec[3];

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Shift all magnitudes together so the largest has its leading one
    // at bit PS_W-1; right shifts truncate toward zero.
    function automatic void prescale_vec(input t_vec v, output t_vec o);
        logic [63:0] m[3];
        logic [63:0] mx;
        int len;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        len = 0;
        for (int b = 0; b < 64; b++) if (mx[b]) len = b + 1;
        for (int i = 0; i < 3; i++) begin
            if (len > lavm_pkg::PS_W) m[i] = m[i] >> (len - lavm_pkg::PS_W);
            else if (len > 0) m[i] = m[i] << (lavm_pkg::PS_W - len);
            o[i] = v[i] < 0 ? -$signed(m[i]) : $signed(m[i]);
        end
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Returns 1 when the vector has zero length.
    function automatic bit unit_vec(input t_vec v, output t_vec o);
        t_vec p;
        logic [63:0] sum, n, q;
        prescale_vec(v, p);
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag64(p[i]) * mag64(p[i]);
        if (sum == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 1'b1;
        end
        n = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag64(p[i]) << FB) + n / 2) / n;
            o[i] = p[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1'b0;
    endfunction

    function automatic void cross_vec(input t_vec a, input t_vec b, output t_vec o);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // -(round half up of (axis . camera) / 2^FB), saturated to 32 bits.
    // The exact sum fits in 64 bits (18-bit axis times 32-bit coordinate).
    function automatic logic [lavm_pkg::OFFSET_W-1:0] row_offset(input t_vec a,
                                                                 input t_vec c);
        logic signed [63:0] acc, res;
        acc = 0;
        for (int i = 0; i < 3; i++) acc += a[i] * c[i];
        res = -((acc + (64'sd1 <<< (FB - 1))) >>> FB);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[lavm_pkg::OFFSET_W-1:0];
    endfunction

    task automatic predict_view_rows(input t_view_req r);
        t_vec cam, dir, up, ups, tmp;
        t_vec axes[3];
        bit degen;
        t_matrix_row row;
        cam[0] = $signed(r.cam_x); cam[1] = $signed(r.cam_y); cam[2] = $signed(r.cam_z);
        dir[0] = cam[0] - $signed(r.tgt_x);
        dir[1] = cam[1] - $signed(r.tgt_y);
        dir[2] = cam[2] - $signed(r.tgt_z);
        up[0] = $signed(r.up_x); up[1] = $signed(r.up_y); up[2] = $signed(r.up_z);
        degen = unit_vec(dir, axes[2]);
        prescale_vec(up, ups);
        cross_vec(ups, axes[2], tmp);
        degen |= unit_vec(tmp, axes[0]);
        cross_vec(axes[2], axes[0], tmp);
        degen |= unit_vec(tmp, axes[1]);
        for (int k = 0; k < lavm_pkg::ROWS; k++) begin
            row.ax = axes[k][0][lavm_pkg::AXIS_W-1:0];
            row.ay = axes[k][1][lavm_pkg::AXIS_W-1:0];
            row.az = axes[k][2][lavm_pkg::AXIS_W-1:0];
            row.offset = row_offset(axes[k], cam);
            row.row = lavm_pkg::ROW_W'(k);
            row.last = (k == lavm_pkg::ROWS - 1);
            row.degen = degen;
            expected_rows.push_back(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return $urandom_range(0, 7);
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    function automatic t_view_req rand_req();
        t_view_req r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        r.cam_x = rand_coord(); r.cam_y = rand_coord(); r.cam_z = rand_coord();
        r.tgt_x = rand_coord(); r.tgt_y = rand_coord(); r.tgt_z = rand_coord();
        r.up_x = rand_coord(); r.up_y = rand_coord(); r.up_z = rand_coord();
        case ($urandom_range(0, 11))
            // A camera sitting on its target.
            0: begin
                r.tgt_x = r.cam_x; r.tgt_y = r.cam_y; r.tgt_z = r.cam_z;
            end
            // Zero up vector.
            1: begin
                r.up_x = '0; r.up_y = '0; r.up_z = '0;
            end
            // Up vector along the viewing direction.
            2: begin
                r.tgt_x = r.cam_x; r.tgt_z = r.cam_z;
                r.up_x = '0; r.up_z = '0;
                r.up_y = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
                r.tgt_y = r.cam_y - 32'h0004_0000;
            end
            // Typical scene with a unit up direction.
            3, 4, 5: begin
                r.up_x = '0; r.up_y = 32'h0001_0000; r.up_z = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_view_req make_req(
        logic [CW-1:0] cx, cy, cz, tx, ty, tz, ux, uy, uz);
        t_view_req r;
        r.cam_x = cx; r.cam_y = cy; r.cam_z = cz;
        r.tgt_x = tx; r.tgt_y = ty; r.tgt_z = tz;
        r.up_x = ux; r.up_y = uy; r.up_z = uz;
        return r;
    endfunction

    initial begin
        localparam logic [CW-1:0] ONE = 32'h0001_0000;
        localparam logic [CW-1:0] MAXC = 32'h7FFF_FFFF;
        localparam logic [CW-1:0] MINC = 32'h8000_0000;
        // Directed: an ordinary view, axis-aligned views and extremes.
        pending_reqs.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
        pending_reqs.push_back(make_req(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0));
        pending_reqs.push_back(make_req(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, ONE, 0));
        pending_reqs.push_back(make_req(MINC, MINC, MINC, MAXC, MAXC, MAXC, ONE, 0, 0));
        pending_reqs.push_back(make_req(MAXC, 0, 0, MINC, 0, 0, 0, MAXC, MINC));
        pending_reqs.push_back(make_req(MINC, MAXC, 0, 0, 0, 0, MINC, MINC, MAXC));
        pending_reqs.push_back(make_req(MAXC, MINC, MAXC, 0, 0, 0, 0, 0, ONE));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, ONE, 0));
        pending_reqs.push_back(make_req(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
        pending_reqs.push_back(make_req(0, 0, ONE, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, ONE, 0, 0, 0, 0, 0, 3 * ONE));
        pending_reqs.push_back(make_req(0, 0, ONE, 0, 0, 0, 0, 0, MINC));
        pending_reqs.push_back(make_req(0, 0, ONE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        0, 0, 0, MAXC, 0, 0));
        pending_reqs.push_back(make_req(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                                        32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA,
                                        32'h0000_8000, 32'h0001_8000, 32'hFFFF_8000));
        for (int n = 0; n < 104; n++) pending_reqs.push_back(rand_req());
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Reset and driver. The sender alternates random bursts and gaps.
    // ------------------------------------------------------------------
    int  burst_left = 0;
    int  gap_left = 0;

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            {i_camera_x, i_camera_y, i_camera_z} <= '0;
            {i_target_x, i_target_y, i_target_z} <= '0;
            {i_up_x, i_up_y, i_up_z} <= '0;
        end else begin
            // Drop the request that was taken at this edge.
            if (start && !busy) begin
                void'(pending_reqs.pop_front());
            end
            if (start && busy) begin
                // Hold the current request until it is accepted.
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
                    gap_left = $urandom_range(1, 20);
                end
                start <= 1'b1;
                i_camera_x <= pending_reqs[0].cam_x;
                i_camera_y <= pending_reqs[0].cam_y;
                i_camera_z <= pending_reqs[0].cam_z;
                i_target_x <= pending_reqs[0].tgt_x;
                i_target_y <= pending_reqs[0].tgt_y;
                i_target_z <= pending_reqs[0].tgt_z;
                i_up_x <= pending_reqs[0].up_x;
                i_up_y <= pending_reqs[0].up_y;
                i_up_z <= pending_reqs[0].up_z;
                predict_view_rows(pending_reqs[0]);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every strobed row is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_matrix_row exp_row;
        if (i_rst_n && o_valid) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected row: row_index %0d", o_row_index);
                fail_count++;
            end else begin
                exp_row = expected_rows.pop_front();
                if (o_axis_x !== exp_row.ax) begin
                    $error("axis_x: expected %h, got %h", exp_row.ax, o_axis_x);
                    fail_count++;
                end
                if (o_axis_y !== exp_row.ay) begin
                    $error("axis_y: expected %h, got %h", exp_row.ay, o_axis_y);
                    fail_count++;
                end
                if (o_axis_z !== exp_row.az) begin
                    $error("axis_z: expected %h, got %h", exp_row.az, o_axis_z);
                    fail_count++;
                end
                if (o_offset !== exp_row.offset) begin
                    $error("offset: expected %h, got %h", exp_row.offset, o_offset);
                    fail_count++;
                end
                if (o_row_index !== exp_row.row) begin
                    $error("row_index: expected %0d, got %0d", exp_row.row, o_row_index);
                    fail_count++;
                end
                if (o_last_row !== exp_row.last) begin
                    $error("last_row: expected %b, got %b", exp_row.last, o_last_row);
                    fail_count++;
                end
                if (o_degenerate !== exp_row.degen) begin
                    $error("degenerate: expected %b, got %b", exp_row.degen, o_degenerate);
                    fail_count++;
                end
            end
        end
    end

    // End of run: all requests taken, all rows seen, then a latency drain.
    initial begin
        wait (stim_done && pending_reqs.size() == 0 && !start);
        wait (expected_rows.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && expected_rows.size() == 0) begin
            $display("look_at_view_matrix_top_tb OK");
        end else begin
            $display("look_at_view_matrix_top_tb NOT OK");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(20ns * 200000);
        $display("look_at_view_matrix_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hdl/lavm_pkg.sv
hdl/lavm_prescale.sv
hdl/lavm_norm.sv
hdl/look_at_view_matrix_top.sv
dv/look_at_view_matrix_top_tb.sv
